/* sv/humidity_temperature_frame_decoder_unit_assert.svh */
// Assertion macros used by the checker file of the frame decoder.
`ifndef HUMIDITY_TEMPERATURE_FRAME_DECODER_UNIT_ASSERT_SVH
`define HUMIDITY_TEMPERATURE_FRAME_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define HTFD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define HTFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that also holds across reset
`define HTFD_ASSERT_RST(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* sv/htfd_pkg.sv */
package htfd_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK  = 2'd0,
        STATUS_CRC = 2'd1,
        STATUS_BUS = 2'd2
    } status_t;

    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam logic [2:0]  LAST_POS    = 3'd5;
    localparam logic [16:0] FULL_SCALE  = 17'd65535;
    localparam logic [10:0] TEMP_SPAN   = 11'd1750;
    localparam logic [10:0] HUM_SPAN    = 11'd1250;
    localparam logic [11:0] TEMP_OFFSET = 12'd450;
    localparam logic [10:0] HUM_OFFSET  = 11'd60;
    localparam logic [10:0] HUM_MAX     = 11'd1000;
    // 65536/10 rounded up, exact for the rounding of 0..1005 tenths
    localparam logic [12:0] RECIP_TEN   = 13'd6554;

    // Fold one byte into a CRC-8 (MSB first, no reflection)
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // Quotient of p / 65535 for p below 2^27: one correction step
    function automatic logic [10:0] div_full_scale(input logic [26:0] p);
        logic [10:0] q0;
        logic [16:0] rem;
        q0  = p[26:16];
        rem = {1'b0, p[15:0]} + {6'd0, q0};
        return q0 + ((rem >= FULL_SCALE) ? 11'd1 : 11'd0);
    endfunction

endpackage

/* sv/humidity_temperature_frame_decoder_unit.sv */
// Humidity and temperature frame decoder.
// Input stream: one response byte per transaction on s_axis_tdata, in frame
// order (word1 high, word1 low, crc1, word2 high, word2 low, crc2), with
// s_axis_tuser set to abort the frame after a failed bus read.
// Output stream: one transaction after each sixth byte or each abort, with
// the stored temperature, the humidity in whole percent, a reset request
// flag on m_axis_tdata and the status code on m_axis_tuser.
// Throughput: one input transaction per cycle, sustained while the master
// side is not stalled. The frame byte counter, the running CRC and the word
// bytes update at the accept edge; the products by the span constants, the
// divide by full scale with clamp, and the percent rounding are three
// register stages that a result passes before the master side shows it.
// A stalled master side holds its result and stalls the whole pipeline:
// s_axis_tready follows m_axis_tready while a result is waiting.
// Reset (aresetn low, synchronous) drops a partial frame, clears the stored
// temperature and humidity to zero and empties the pipeline.
module humidity_temperature_frame_decoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] bus_abort
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [11:0] temperature_tenths, [18:12] humidity_percent,
                                        // [19] reset_request, [23:20] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import htfd_pkg::*;

    logic               advance;
    logic               accept;
    logic               last_byte;

    logic [2:0]         pos_reg;
    logic [7:0]         crc_reg;
    logic               crc1_ok_reg;
    logic [7:0]         w1_hi_reg, w1_lo_reg, w2_hi_reg, w2_lo_reg;

    logic               res1_reg;
    status_t            status1_reg;
    logic [26:0]        prod_t1_reg, prod_h1_reg;

    logic [10:0]        q_t, q_h;
    logic signed [11:0] temp_next;
    logic [9:0]         hum_next;
    logic               hum_rst;

    logic               res2_reg;
    status_t            status2_reg;
    logic               rst2_reg;
    logic signed [11:0] stored_temp_reg;
    logic [9:0]         stored_hum_reg;

    logic [23:0]        pct_prod;
    logic               m_valid_reg;
    logic signed [11:0] m_temp_reg;
    logic [6:0]         m_hum_reg;
    status_t            m_status_reg;
    logic               m_rst_reg;

    // Move the whole pipeline when the output register is free or taken
    assign advance       = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;
    assign accept        = s_axis_tvalid && advance;
    assign last_byte     = pos_reg >= LAST_POS;

    // Track the byte position within the frame
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (accept) begin
            if (s_axis_tuser || last_byte) begin
                pos_reg <= '0;
            end else begin
                pos_reg <= pos_reg + 3'd1;
            end
        end
    end

    // Capture word bytes and run the CRC over each word
    always_ff @(posedge aclk) begin
        if (accept && !s_axis_tuser) begin
            unique case (pos_reg)
                3'd0: begin
                    w1_hi_reg <= s_axis_tdata;
                    crc_reg   <= crc8_step(CRC_INIT, s_axis_tdata);
                end
                3'd1: begin
                    w1_lo_reg <= s_axis_tdata;
                    crc_reg   <= crc8_step(crc_reg, s_axis_tdata);
                end
                3'd2: begin
                    crc1_ok_reg <= (crc_reg == s_axis_tdata);
                end
                3'd3: begin
                    w2_hi_reg <= s_axis_tdata;
                    crc_reg   <= crc8_step(CRC_INIT, s_axis_tdata);
                end
                3'd4: begin
                    w2_lo_reg <= s_axis_tdata;
                    crc_reg   <= crc8_step(crc_reg, s_axis_tdata);
                end
                default: begin
                end
            endcase
        end
    end

    // Stage 1: classify the closing transaction and scale both words
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res1_reg <= 1'b0;
        end else if (advance) begin
            res1_reg <= accept && (s_axis_tuser || last_byte);
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            if (s_axis_tuser) begin
                status1_reg <= STATUS_BUS;
            end else if (!crc1_ok_reg || (crc_reg != s_axis_tdata)) begin
                status1_reg <= STATUS_CRC;
            end else begin
                status1_reg <= STATUS_OK;
            end
            prod_t1_reg <= 27'({w1_hi_reg, w1_lo_reg}) * 27'(TEMP_SPAN);
            prod_h1_reg <= 27'({w2_hi_reg, w2_lo_reg}) * 27'(HUM_SPAN);
        end
    end

    // Stage 2: divide by full scale, remove offsets, clamp humidity
    always_comb begin
        q_t       = div_full_scale(prod_t1_reg);
        q_h       = div_full_scale(prod_h1_reg);
        temp_next = $signed({1'b0, q_t}) - $signed(TEMP_OFFSET);
        hum_rst   = 1'b0;
        if (q_h < HUM_OFFSET) begin
            hum_next = '0;
            hum_rst  = 1'b1;
        end else if ((q_h - HUM_OFFSET) > HUM_MAX) begin
            hum_next = HUM_MAX[9:0];
            hum_rst  = 1'b1;
        end else begin
            hum_next = 10'(q_h - HUM_OFFSET);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res2_reg        <= 1'b0;
            stored_temp_reg <= '0;
            stored_hum_reg  <= '0;
        end else if (advance) begin
            res2_reg <= res1_reg;
            if (res1_reg && (status1_reg == STATUS_OK)) begin
                stored_temp_reg <= temp_next;
                stored_hum_reg  <= hum_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            status2_reg <= status1_reg;
            rst2_reg    <= (status1_reg == STATUS_BUS) ||
                           ((status1_reg == STATUS_OK) && hum_rst);
        end
    end

    // Stage 3: round humidity to whole percent and hold the result
    assign pct_prod = (24'(stored_hum_reg) + 24'd5) * 24'(RECIP_TEN);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= res2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_temp_reg   <= stored_temp_reg;
            m_hum_reg    <= pct_prod[22:16];
            m_status_reg <= status2_reg;
            m_rst_reg    <= rst2_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'd0, m_rst_reg, m_hum_reg, m_temp_reg};
    assign m_axis_tuser  = m_status_reg;

endmodule

/* sv/htfd_checker.sv */
`include "humidity_temperature_frame_decoder_unit_assert.svh"

module htfd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,   // [11:0] temperature_tenths, [18:12] humidity_percent,
                                       // [19] reset_request, [23:20] zero
    input logic [1:0]  m_axis_tuser    // [1:0] status
);
    import htfd_pkg::*;

    logic m_stall;

    assign m_stall = m_axis_tvalid && !m_axis_tready;

    // Hold a stalled result unchanged
    `HTFD_ASSERT_NEXT(a_stall_hold, m_stall, m_axis_tvalid && $stable({m_axis_tdata, m_axis_tuser}))

    // A failed bus read always asks for a soft reset
    `HTFD_ASSERT_NOW(a_bus_reset, m_axis_tvalid && (m_axis_tuser == STATUS_BUS), m_axis_tdata[19])

    // A checksum mismatch never asks for a soft reset
    `HTFD_ASSERT_NOW(a_crc_no_reset, m_axis_tvalid && (m_axis_tuser == STATUS_CRC), !m_axis_tdata[19])

    // Rounded humidity stays within 0..100 percent
    `HTFD_ASSERT_NOW(a_hum_range, m_axis_tvalid, m_axis_tdata[18:12] <= 7'd100)

    // Reset empties the output and opens the input side
    `HTFD_ASSERT_RST(a_reset_empty, !aresetn, !m_axis_tvalid && s_axis_tready)

endmodule

bind humidity_temperature_frame_decoder_unit htfd_checker u_htfd_checker (.*);

/* tb/htfd_reading_checker.sv */
module htfd_reading_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] bus_abort
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,   // [11:0] temperature_tenths, [18:12] humidity_percent,
                                        // [19] reset_request, [23:20] zero
    input  logic [1:0]  m_axis_tuser,   // [1:0] status
    output int          failures,
    output int          pending
);
    import htfd_pkg::*;

    localparam int FULL_SCALE_C  = 65535;
    localparam int TEMP_SPAN_C   = 1750;
    localparam int TEMP_OFFSET_C = 450;
    localparam int HUM_SPAN_C    = 1250;
    localparam int HUM_OFFSET_C  = 60;
    localparam int HUM_MAX_C     = 1000;
    localparam int FRAME_LAST    = 5;

    typedef struct {
        logic signed [11:0] temperature;
        logic [6:0]         humidity;
        status_t            status;
        logic               reset_req;
    } reading_t;

    reading_t expected_readings[$];

    // Decoder state mirrored from the block
    logic [2:0]         frame_pos;
    logic [7:0]         frame_bytes [0:4];
    logic signed [11:0] temp_reading;
    logic [9:0]         hum_tenths;

    // CRC-8, poly 0x31, init 0xFF, shifted one bit at a time
    function automatic logic [7:0] word_crc(input logic [15:0] w);
        logic [7:0] crc;
        logic       fb;
        crc = 8'hFF;
        for (int i = 15; i >= 0; i--) begin
            fb  = crc[7] ^ w[i];
            crc = {crc[6:0], 1'b0} ^ (fb ? 8'h31 : 8'h00);
        end
        return crc;
    endfunction

    function automatic reading_t stored_reading(input status_t st, input logic rq);
        reading_t r;
        r.temperature = temp_reading;
        r.humidity    = 7'((int'(hum_tenths) + 5) / 10);
        r.status      = st;
        r.reset_req   = rq;
        return r;
    endfunction

    // Advance the decoder by one byte and queue the reading it produces
    task automatic decode_rx_byte(input logic [7:0] b, input logic abort_now);
        int   w1;
        int   w2;
        int   hum;
        logic rq;
        if (abort_now) begin
            frame_pos = '0;
            expected_readings.push_back(stored_reading(STATUS_BUS, 1'b1));
        end else if (frame_pos < FRAME_LAST) begin
            frame_bytes[frame_pos] = b;
            frame_pos = frame_pos + 3'd1;
        end else begin
            frame_pos = '0;
            w1 = int'({frame_bytes[0], frame_bytes[1]});
            w2 = int'({frame_bytes[3], frame_bytes[4]});
            if (word_crc(16'(w1)) != frame_bytes[2] || word_crc(16'(w2)) != b) begin
                expected_readings.push_back(stored_reading(STATUS_CRC, 1'b0));
            end else begin
                rq  = 1'b0;
                hum = w2 * HUM_SPAN_C / FULL_SCALE_C - HUM_OFFSET_C;
                if (hum < 0) begin
                    hum = 0;
                    rq  = 1'b1;
                end else if (hum > HUM_MAX_C) begin
                    hum = HUM_MAX_C;
                    rq  = 1'b1;
                end
                temp_reading = 12'(w1 * TEMP_SPAN_C / FULL_SCALE_C - TEMP_OFFSET_C);
                hum_tenths   = 10'(hum);
                expected_readings.push_back(stored_reading(STATUS_OK, rq));
            end
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s expected %0d got %0d", name, want, got);
            failures++;
        end
    endtask

    // Compare the outgoing transaction first, then fold in the incoming one
    always @(posedge aclk) begin : watch
        reading_t want;
        if (!aresetn) begin
            frame_pos    = '0;
            temp_reading = '0;
            hum_tenths   = '0;
            for (int i = 0; i <= 4; i++) frame_bytes[i] = '0;
            expected_readings.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_readings.size() == 0) begin
                    $error("result transaction with no reading expected");
                    failures++;
                end else begin
                    want = expected_readings.pop_front();
                    check_field("temperature_tenths", int'(want.temperature),
                                int'($signed(m_axis_tdata[11:0])));
                    check_field("humidity_percent", int'(want.humidity),
                                int'(m_axis_tdata[18:12]));
                    check_field("status", int'(want.status), int'(m_axis_tuser));
                    check_field("reset_request", int'(want.reset_req),
                                int'(m_axis_tdata[19]));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                decode_rx_byte(s_axis_tdata, s_axis_tuser);
            end
        end
        pending = expected_readings.size();
    end

endmodule

/* tb/tb_top.sv */
module tb_top;

    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int RANDOM_BYTES  = 400;
    // Which check byte of a frame gets a flipped bit
    localparam int CORRUPT_NONE  = 0;
    localparam int CORRUPT_WORD1 = 1;
    localparam int CORRUPT_WORD2 = 2;
    // Receiver stall patterns
    localparam int RX_READY      = 0;
    localparam int RX_LIGHT      = 1;
    localparam int RX_HEAVY      = 2;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
    logic        s_axis_tuser;   // [0] bus_abort
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;   // [11:0] temperature_tenths, [18:12] humidity_percent,
                                 // [19] reset_request, [23:20] zero
    logic [1:0]  m_axis_tuser;   // [1:0] status

    int   reading_failures;
    int   readings_pending;
    logic s_took = 1'b0;
    logic m_took = 1'b0;
    int   burst_left = 0;
    int   bytes_sent = 0;
    int   rx_left = 0;
    int   rx_mode = RX_READY;
    int   idle_cycles;

    humidity_temperature_frame_decoder_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    htfd_reading_checker u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .failures      (reading_failures),
        .pending       (readings_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Record handshakes at the rising edge for use at the falling edge
    always @(posedge aclk) begin
        s_took <= s_axis_tvalid && s_axis_tready;
        m_took <= m_axis_tvalid && m_axis_tready;
    end

    // Receiver: switch between always ready, light stalls and heavy stalls
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(RX_READY, RX_HEAVY);
            rx_left <= $urandom_range(16, 96);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_READY: begin
                m_axis_tready <= 1'b1;
            end
            RX_LIGHT: begin
                m_axis_tready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                m_axis_tready <= ($urandom_range(0, 9) == 0);
            end
        endcase
    end

    // Watchdog: end the run when nothing moves for too long
    initial begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(negedge aclk);
            if (!aresetn || s_took || m_took) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("humidity_temperature_frame_decoder_unit verification failed");
        $finish;
    end

    function automatic logic [7:0] frame_crc(input logic [15:0] w);
        logic [7:0] crc;
        crc = 8'hFF;
        for (int i = 15; i >= 0; i--) begin
            crc = {crc[6:0], 1'b0} ^ ((crc[7] ^ w[i]) ? 8'h31 : 8'h00);
        end
        return crc;
    endfunction

    // Bias words toward the ends of the range and the humidity clamp regions
    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0: begin
                return 16'h0000;
            end
            1: begin
                return 16'hFFFF;
            end
            2: begin
                return 16'($urandom_range(0, 3400));
            end
            3: begin
                return 16'($urandom_range(55000, 65535));
            end
            default: begin
                return 16'($urandom);
            end
        endcase
    endfunction

    // Send one byte at a falling edge; hold until the transaction is taken
    task automatic send_byte(input logic [7:0] b, input logic abort_now);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(24, 64)
                                                    : $urandom_range(1, 8);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        s_axis_tuser  = abort_now;
        do @(negedge aclk); while (!s_took);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [15:0] w1, input logic [15:0] w2, input int corrupt);
        logic [7:0] c1;
        logic [7:0] c2;
        c1 = frame_crc(w1);
        c2 = frame_crc(w2);
        if (corrupt == CORRUPT_WORD1) c1 = c1 ^ (8'd1 << $urandom_range(0, 7));
        if (corrupt == CORRUPT_WORD2) c2 = c2 ^ (8'd1 << $urandom_range(0, 7));
        send_byte(w1[15:8], 1'b0);
        send_byte(w1[7:0], 1'b0);
        send_byte(c1, 1'b0);
        send_byte(w2[15:8], 1'b0);
        send_byte(w2[7:0], 1'b0);
        send_byte(c2, 1'b0);
    endtask

    initial begin
        int pick;
        int partial;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        aresetn       = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: range ends with both humidity clamps, bad check byte, aborts
        send_frame(16'h0000, 16'h0000, CORRUPT_NONE);
        send_frame(16'hFFFF, 16'hFFFF, CORRUPT_NONE);
        send_frame(16'h6666, 16'h8000, CORRUPT_WORD2);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);

        // Random: mostly clean frames, some corrupted, cut short or misaligned
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 68) begin
                send_frame(pick_word(), pick_word(), CORRUPT_NONE);
            end else if (pick < 78) begin
                send_frame(pick_word(), pick_word(),
                           ($urandom_range(0, 1) == 0) ? CORRUPT_WORD1 : CORRUPT_WORD2);
            end else if (pick < 90) begin
                partial = $urandom_range(0, 5);
                repeat (partial) send_byte(8'($urandom), 1'b0);
                send_byte(8'($urandom), 1'b1);
            end else if (pick < 96) begin
                send_byte(8'($urandom), 1'b1);
            end else begin
                send_byte(8'($urandom), 1'b0);
            end
        end
        s_axis_tvalid = 1'b0;

        // Drain outstanding readings, then watch for strays
        while (readings_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (reading_failures == 0) begin
            $display("humidity_temperature_frame_decoder_unit verification clean");
        end else begin
            $display("humidity_temperature_frame_decoder_unit verification failed");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/htfd_pkg.sv
sv/humidity_temperature_frame_decoder_unit.sv
sv/htfd_checker.sv
tb/htfd_reading_checker.sv
tb/tb_top.sv
